### hdl/rc4_stream_cipher_assert.svh
// Assertion macros for the RTL core; clk_i and rst_ni are taken from the enclosing module.
`ifndef RC4_STREAM_CIPHER_ASSERT_SVH
`define RC4_STREAM_CIPHER_ASSERT_SVH

// Same-cycle implication.
`define RC4_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rc4: same-cycle check failed");

// Next-cycle implication.
`define RC4_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rc4: next-cycle check failed");

`endif

### hdl/rc4_pkg.sv
package rc4_pkg;

  localparam int unsigned MaxKeyBytes = 256;
  localparam int unsigned PermSize    = 256;
  localparam int unsigned ByteW       = 8;

  typedef logic [ByteW-1:0] byte_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FILL,
    ST_K0,
    ST_K1,
    ST_K2,
    ST_K3,
    ST_DONE,
    ST_G1,
    ST_G2,
    ST_G3
  } step_e;

  typedef enum logic [1:0] {
    RD_I_NEXT,
    RD_N,
    RD_J_NEW,
    RD_T
  } rd_sel_e;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_FILL,
    WR_N_SJ,
    WR_J_SI,
    WR_I_SJ
  } wr_sel_e;

  typedef enum logic [2:0] {
    SEQ_DISPATCH,
    SEQ_NEXT,
    SEQ_LOOP,
    SEQ_FINISH,
    SEQ_RETURN
  } seq_e;

  typedef struct packed {
    rd_sel_e rd_sel;
    wr_sel_e wr_sel;
    logic    ld_j;
    logic    add_key;
    logic    ld_sj;
    logic    adv_n;
    logic    adv_k;
    logic    emit;
    seq_e    seq;
    step_e   target;
  } ctrl_t;

  function automatic ctrl_t ucode(step_e s);
    ctrl_t c;
    c = '{rd_sel: RD_I_NEXT, wr_sel: WR_NONE, ld_j: 1'b0, add_key: 1'b0, ld_sj: 1'b0,
          adv_n: 1'b0, adv_k: 1'b0, emit: 1'b0, seq: SEQ_NEXT, target: ST_IDLE};
    case (s)
      ST_IDLE: begin
        c.seq = SEQ_DISPATCH;
      end
      ST_FILL: begin
        c.wr_sel = WR_FILL;
        c.adv_n  = 1'b1;
        c.seq    = SEQ_LOOP;
        c.target = ST_FILL;
      end
      ST_K0: begin
        c.rd_sel = RD_N;
      end
      ST_K1: begin
        c.rd_sel  = RD_J_NEW;
        c.ld_j    = 1'b1;
        c.add_key = 1'b1;
      end
      ST_K2: begin
        c.ld_sj  = 1'b1;
        c.wr_sel = WR_N_SJ;
      end
      ST_K3: begin
        c.wr_sel = WR_J_SI;
        c.adv_n  = 1'b1;
        c.adv_k  = 1'b1;
        c.seq    = SEQ_LOOP;
        c.target = ST_K0;
      end
      ST_DONE: begin
        c.seq = SEQ_FINISH;
      end
      ST_G1: begin
        c.rd_sel = RD_J_NEW;
        c.ld_j   = 1'b1;
      end
      ST_G2: begin
        c.rd_sel = RD_T;
        c.ld_sj  = 1'b1;
        c.wr_sel = WR_I_SJ;
      end
      ST_G3: begin
        c.wr_sel = WR_J_SI;
        c.emit   = 1'b1;
        c.seq    = SEQ_RETURN;
      end
      default: begin
        c.seq = SEQ_RETURN;
      end
    endcase
    return c;
  endfunction

endpackage

### hdl/rc4_if.sv
interface rc4_in_if;
  logic                         valid;
  logic                         ready;
  logic                         kind;
  logic [rc4_pkg::ByteW-1:0]    key_byte;
  logic                         key_last;
  logic [rc4_pkg::ByteW-1:0]    data_byte;

  modport source (output valid, kind, key_byte, key_last, data_byte, input ready);
  modport sink (input valid, kind, key_byte, key_last, data_byte, output ready);
endinterface

interface rc4_out_if;
  logic                         valid;
  logic                         ready;
  logic [rc4_pkg::ByteW-1:0]    keystream_byte;
  logic [rc4_pkg::ByteW-1:0]    result_byte;
  logic                         no_key;

  modport source (output valid, keystream_byte, result_byte, no_key, input ready);
  modport sink (input valid, keystream_byte, result_byte, no_key, output ready);
endinterface

### hdl/rc4_ram.sv
module rc4_ram #(
  parameter int unsigned Width = rc4_pkg::ByteW,
  parameter int unsigned Depth = rc4_pkg::PermSize
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                      wdata_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                      rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### hdl/rc4_stream_cipher.sv
// Channel  Dir  Payload                                     Handshake
// in_i     in   kind, key_byte, key_last, data_byte         valid/ready
// out_o    out  keystream_byte, result_byte, no_key         valid/ready
//
// A keyed data item passes through the idle step that takes it, which reads S[i], then G1, G2
// and G3: S[j] and S[S[i]+S[j]] follow, each a registered read, and G3 loads the result.
// The final key byte starts the schedule: a fill step per entry, then the swap steps K0..K3
// per entry and a closing step, during which no item is taken. Other items stay in idle.
// Reset leaves the core idle and unkeyed with an empty result register. Items are taken
// only in the idle step while the result register is empty or being drained.
module rc4_stream_cipher #(
  parameter int unsigned MAX_KEY_BYTES = rc4_pkg::MaxKeyBytes
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  rc4_in_if.sink    in_i,
  rc4_out_if.source out_o
);

  localparam int unsigned KAW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
  localparam int unsigned KCW = $clog2(MAX_KEY_BYTES + 1);
  localparam int unsigned PAW = $clog2(rc4_pkg::PermSize);

  rc4_pkg::step_e step_q, step_d;
  rc4_pkg::ctrl_t ctrl;

  logic [PAW-1:0] i_q, i_d, j_q, j_d, n_q, n_d;
  logic [KAW-1:0] k_q, k_d;
  logic [KCW-1:0] kcnt_q, kcnt_d, kcnt_base;
  logic           keyed_q, keyed_d, loading_q, loading_d;
  logic           out_valid_q, out_valid_d;

  rc4_pkg::byte_t si_q, sj_q, t_q, data_q, ks_q, res_q;
  logic           out_nokey_q;

  rc4_pkg::byte_t perm_rdata, key_rdata, j_sum, ks_byp;
  logic [PAW-1:0] perm_raddr, perm_waddr;
  rc4_pkg::byte_t perm_wdata;
  logic           perm_we, key_we;

  logic in_rdy, in_acc, out_pop, n_last, k_wrap;

  assign ctrl    = rc4_pkg::ucode(step_q);
  assign out_pop = out_valid_q && out_o.ready;
  assign in_rdy  = (step_q == rc4_pkg::ST_IDLE) && (!out_valid_q || out_o.ready);
  assign in_acc  = in_i.valid && in_rdy;
  assign n_last  = (n_q == PAW'(rc4_pkg::PermSize - 1));
  assign k_wrap  = ((KCW'(k_q) + KCW'(1)) == kcnt_q);

  assign kcnt_base = loading_q ? kcnt_q : '0;
  assign key_we    = in_acc && !in_i.kind && (kcnt_base < KCW'(MAX_KEY_BYTES));

  assign j_sum  = j_q + perm_rdata + (ctrl.add_key ? key_rdata : '0);
  assign ks_byp = (t_q == j_q) ? si_q : ((t_q == i_q) ? sj_q : perm_rdata);

  always_comb begin
    perm_raddr = i_q + PAW'(1);
    case (ctrl.rd_sel)
      rc4_pkg::RD_I_NEXT: perm_raddr = i_q + PAW'(1);
      rc4_pkg::RD_N:      perm_raddr = n_q;
      rc4_pkg::RD_J_NEW:  perm_raddr = j_sum;
      rc4_pkg::RD_T:      perm_raddr = si_q + perm_rdata;
      default:            perm_raddr = i_q + PAW'(1);
    endcase
  end

  always_comb begin
    perm_we    = 1'b1;
    perm_waddr = n_q;
    perm_wdata = perm_rdata;
    case (ctrl.wr_sel)
      rc4_pkg::WR_NONE: perm_we = 1'b0;
      rc4_pkg::WR_FILL: begin
        perm_waddr = n_q;
        perm_wdata = n_q;
      end
      rc4_pkg::WR_N_SJ: begin
        perm_waddr = n_q;
        perm_wdata = perm_rdata;
      end
      rc4_pkg::WR_J_SI: begin
        perm_waddr = j_q;
        perm_wdata = si_q;
      end
      rc4_pkg::WR_I_SJ: begin
        perm_waddr = i_q;
        perm_wdata = perm_rdata;
      end
      default: perm_we = 1'b0;
    endcase
  end

  rc4_ram #(
    .Width (rc4_pkg::ByteW),
    .Depth (rc4_pkg::PermSize)
  ) u_perm_ram (
    .clk_i   (clk_i),
    .we_i    (perm_we),
    .waddr_i (perm_waddr),
    .wdata_i (perm_wdata),
    .raddr_i (perm_raddr),
    .rdata_o (perm_rdata)
  );

  rc4_ram #(
    .Width (rc4_pkg::ByteW),
    .Depth (MAX_KEY_BYTES)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (kcnt_base[KAW-1:0]),
    .wdata_i (in_i.key_byte),
    .raddr_i (k_q),
    .rdata_o (key_rdata)
  );

  always_comb begin
    step_d      = step_q;
    i_d         = i_q;
    j_d         = ctrl.ld_j ? j_sum : j_q;
    n_d         = ctrl.adv_n ? n_q + PAW'(1) : n_q;
    k_d         = k_q;
    kcnt_d      = kcnt_q;
    keyed_d     = keyed_q;
    loading_d   = loading_q;
    out_valid_d = out_pop ? 1'b0 : out_valid_q;

    if (ctrl.adv_k) begin
      k_d = k_wrap ? '0 : k_q + KAW'(1);
    end
    if (ctrl.emit) begin
      out_valid_d = 1'b1;
    end

    case (ctrl.seq)
      rc4_pkg::SEQ_DISPATCH: begin
        if (in_acc) begin
          if (!in_i.kind) begin
            loading_d = 1'b1;
            kcnt_d    = key_we ? kcnt_base + KCW'(1) : kcnt_base;
            if (in_i.key_last) begin
              step_d = rc4_pkg::ST_FILL;
              n_d    = '0;
              j_d    = '0;
              k_d    = '0;
            end
          end else if (keyed_q) begin
            i_d    = i_q + PAW'(1);
            step_d = rc4_pkg::ST_G1;
          end else begin
            out_valid_d = 1'b1;
          end
        end
      end
      rc4_pkg::SEQ_NEXT: step_d = rc4_pkg::step_e'(step_q + 4'd1);
      rc4_pkg::SEQ_LOOP: begin
        step_d = n_last ? rc4_pkg::step_e'(step_q + 4'd1) : ctrl.target;
      end
      rc4_pkg::SEQ_FINISH: begin
        i_d       = '0;
        j_d       = '0;
        keyed_d   = 1'b1;
        loading_d = 1'b0;
        step_d    = rc4_pkg::ST_IDLE;
      end
      rc4_pkg::SEQ_RETURN: step_d = rc4_pkg::ST_IDLE;
      default:             step_d = rc4_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= rc4_pkg::ST_IDLE;
      i_q         <= '0;
      j_q         <= '0;
      n_q         <= '0;
      k_q         <= '0;
      kcnt_q      <= '0;
      keyed_q     <= 1'b0;
      loading_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      i_q         <= i_d;
      j_q         <= j_d;
      n_q         <= n_d;
      k_q         <= k_d;
      kcnt_q      <= kcnt_d;
      keyed_q     <= keyed_d;
      loading_q   <= loading_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.ld_j) begin
      si_q <= perm_rdata;
    end
    if (ctrl.ld_sj) begin
      sj_q <= perm_rdata;
      t_q  <= si_q + perm_rdata;
    end
    if (in_acc) begin
      data_q <= in_i.data_byte;
    end
    if (in_acc && in_i.kind && !keyed_q) begin
      ks_q        <= '0;
      res_q       <= in_i.data_byte;
      out_nokey_q <= 1'b1;
    end else if (ctrl.emit) begin
      ks_q        <= ks_byp;
      res_q       <= data_q ^ ks_byp;
      out_nokey_q <= 1'b0;
    end
  end

  assign in_i.ready           = in_rdy;
  assign out_o.valid          = out_valid_q;
  assign out_o.keystream_byte = ks_q;
  assign out_o.result_byte    = res_q;
  assign out_o.no_key         = out_nokey_q;

`include "rc4_stream_cipher_assert.svh"

  `RC4_ASSERT_NXT(a_data_starts_gen, in_acc && in_i.kind && keyed_q, step_q == rc4_pkg::ST_G1)
  `RC4_ASSERT_NXT(a_gen_emits, step_q == rc4_pkg::ST_G3, out_valid_q && !out_nokey_q)
  `RC4_ASSERT_IMP(a_nokey_unkeyed, out_valid_q && out_nokey_q, !keyed_q)
  `RC4_ASSERT_IMP(a_count_cap, loading_q, kcnt_q <= KCW'(MAX_KEY_BYTES))

endmodule

### test/tb_rc4_stream_cipher.sv
module tb_rc4_stream_cipher;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned KeyCap       = rc4_pkg::MaxKeyBytes;
  localparam int unsigned PermSize     = rc4_pkg::PermSize;
  localparam int unsigned HalfPeriod   = 10;
  localparam int unsigned RandItems    = 1350;
  localparam int unsigned SettleCycles = 1300;
  localparam int unsigned CycleLimit   = 5_000_000;
  localparam int unsigned MaxReports   = 10;

  localparam logic KindKey  = 1'b0;
  localparam logic KindData = 1'b1;

  typedef struct packed {
    logic           hold;
    logic           kind;
    rc4_pkg::byte_t key_byte;
    logic           key_last;
    rc4_pkg::byte_t data_byte;
  } feed_item_t;

  typedef struct packed {
    rc4_pkg::byte_t keystream;
    rc4_pkg::byte_t result;
    logic           no_key;
  } cipher_out_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  rc4_in_if  in_if ();
  rc4_out_if out_if ();

  rc4_stream_cipher #(
    .MAX_KEY_BYTES(KeyCap)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  feed_item_t  byte_feed[$];
  feed_item_t  on_bus;
  cipher_out_t keystream_due[$];

  rc4_pkg::byte_t sbox    [PermSize];
  rc4_pkg::byte_t key_mem [PermSize];
  int unsigned    key_len  = 0;
  rc4_pkg::byte_t idx_i    = '0;
  rc4_pkg::byte_t idx_j    = '0;
  logic           have_key = 1'b0;
  logic           mid_load = 1'b0;

  int unsigned feed_gap    = 0;
  int unsigned ready_gap   = 0;
  logic        feed_burst  = 1'b0;
  logic        drain_burst = 1'b0;

  int unsigned stim_count = 0;
  int unsigned key_items  = 0;
  int unsigned data_items = 0;
  int unsigned schedules  = 0;
  int unsigned checked    = 0;
  int unsigned failures   = 0;
  int unsigned cycles     = 0;

  always #HalfPeriod clk_i = ~clk_i;

  function automatic void advance_cipher(input feed_item_t it);
    rc4_pkg::byte_t j;
    rc4_pkg::byte_t t;
    rc4_pkg::byte_t ks;
    int unsigned    span;
    if (it.kind == KindKey) begin
      key_items++;
      if (!mid_load) begin
        mid_load = 1'b1;
        key_len  = 0;
      end
      if (key_len < KeyCap) begin
        key_mem[key_len % PermSize] = it.key_byte;
        key_len++;
      end
      if (it.key_last) begin
        span = (key_len == 0) ? 1 : key_len;
        for (int n = 0; n < PermSize; n++) sbox[n] = rc4_pkg::byte_t'(n);
        j = '0;
        for (int n = 0; n < PermSize; n++) begin
          j       = j + sbox[n] + key_mem[n % span];
          t       = sbox[n];
          sbox[n] = sbox[j];
          sbox[j] = t;
        end
        idx_i    = '0;
        idx_j    = '0;
        have_key = 1'b1;
        mid_load = 1'b0;
        schedules++;
      end
    end else begin
      data_items++;
      if (!have_key) begin
        keystream_due.push_back('{keystream: '0, result: it.data_byte, no_key: 1'b1});
      end else begin
        idx_i       = idx_i + 8'd1;
        idx_j       = idx_j + sbox[idx_i];
        t           = sbox[idx_i];
        sbox[idx_i] = sbox[idx_j];
        sbox[idx_j] = t;
        ks          = sbox[rc4_pkg::byte_t'(sbox[idx_i] + sbox[idx_j])];
        keystream_due.push_back('{keystream: ks, result: it.data_byte ^ ks, no_key: 1'b0});
      end
    end
  endfunction

  function automatic int unsigned pick_gap(input logic burst);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (burst || roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void note_failure(input string msg);
    failures++;
    if (failures <= MaxReports) $display("MISMATCH: %s", msg);
  endfunction

  task automatic feed(input logic kind, input rc4_pkg::byte_t kb, input logic last,
                      input rc4_pkg::byte_t db, input logic hold = 1'b0);
    byte_feed.push_back('{hold: hold, kind: kind, key_byte: kb, key_last: last, data_byte: db});
  endtask

  task automatic feed_key(input int unsigned len, input logic closing);
    for (int unsigned k = 0; k < len; k++) begin
      feed(KindKey, rc4_pkg::byte_t'($urandom), closing && (k == len - 1),
           rc4_pkg::byte_t'($urandom), $urandom_range(0, 99) == 0);
    end
    stim_count += len;
  endtask

  task automatic feed_data(input int unsigned count);
    for (int unsigned k = 0; k < count; k++) begin
      feed(KindData, rc4_pkg::byte_t'($urandom), 1'($urandom), rc4_pkg::byte_t'($urandom),
           $urandom_range(0, 99) == 0);
    end
    stim_count += count;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid     <= 1'b0;
      in_if.kind      <= KindKey;
      in_if.key_byte  <= '0;
      in_if.key_last  <= 1'b0;
      in_if.data_byte <= '0;
      feed_gap = 0;
    end else begin
      if (in_if.valid && in_if.ready) advance_cipher(on_bus);
      if (!in_if.valid || in_if.ready) begin
        if (feed_gap != 0) begin
          feed_gap--;
          in_if.valid <= 1'b0;
        end else if (byte_feed.size() != 0 &&
                     !(byte_feed[0].hold && keystream_due.size() != 0)) begin
          on_bus = byte_feed.pop_front();
          in_if.valid     <= 1'b1;
          in_if.kind      <= on_bus.kind;
          in_if.key_byte  <= on_bus.key_byte;
          in_if.key_last  <= on_bus.key_last;
          in_if.data_byte <= on_bus.data_byte;
          feed_gap = pick_gap(feed_burst);
          if ($urandom_range(0, 39) == 0) feed_burst = !feed_burst;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    cipher_out_t want;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      ready_gap = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (keystream_due.size() == 0) begin
          note_failure($sformatf("unexpected result ks=%02h res=%02h no_key=%0b",
                                 out_if.keystream_byte, out_if.result_byte, out_if.no_key));
        end else begin
          want = keystream_due.pop_front();
          checked++;
          if (out_if.keystream_byte !== want.keystream ||
              out_if.result_byte !== want.result ||
              out_if.no_key !== want.no_key) begin
            note_failure($sformatf(
              "result %0d: expected ks=%02h res=%02h no_key=%0b, got ks=%02h res=%02h no_key=%0b",
              checked, want.keystream, want.result, want.no_key,
              out_if.keystream_byte, out_if.result_byte, out_if.no_key));
          end
        end
      end
      if (ready_gap != 0) begin
        ready_gap--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
        ready_gap = pick_gap(drain_burst);
        if ($urandom_range(0, 59) == 0) drain_burst = !drain_burst;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("Timed out after %0d cycles", cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    int unsigned pick;
    rst_ni = 1'b0;

    feed(KindData, 8'h00, 1'b1, 8'h00);
    feed(KindData, 8'hFF, 1'b0, 8'hFF);
    feed(KindKey, 8'h00, 1'b0, 8'hFF);
    feed(KindKey, 8'hFF, 1'b1, 8'h00);
    feed(KindData, 8'h00, 1'b0, 8'h00);
    feed(KindData, 8'hFF, 1'b1, 8'hFF);
    feed_data(3);
    // hold until drained, then open a new load and send data through the old key
    feed(KindKey, 8'h80, 1'b0, 8'h00, 1'b1);
    feed_data(3);
    feed(KindKey, 8'h7F, 1'b1, 8'h00);
    feed_data(4);
    feed(KindKey, 8'hA5, 1'b1, 8'h5A);
    feed_data(3);

    stim_count = 0;
    while (stim_count < RandItems) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        feed_key($urandom_range(1, 16), 1'b1);
        feed_data($urandom_range(1, 40));
      end else if (pick < 82) begin
        feed_key($urandom_range(1, 8), 1'b0);
        feed_data($urandom_range(1, 10));
        feed_key($urandom_range(1, 4), 1'b1);
        feed_data($urandom_range(1, 20));
      end else if (pick < 92) begin
        feed_data($urandom_range(1, 20));
      end else if (pick < 97) begin
        feed_key($urandom_range(17, 255), 1'b1);
        feed_data($urandom_range(1, 20));
      end else begin
        feed_key($urandom_range(256, 300), 1'b1);
        feed_data($urandom_range(1, 20));
      end
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (byte_feed.size() != 0 || in_if.valid || keystream_due.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (SettleCycles) @(posedge clk_i);

    if (keystream_due.size() != 0) begin
      failures += keystream_due.size();
      $display("%0d expected results never arrived", keystream_due.size());
    end

    $display("Covered %0d key bytes, %0d data bytes and %0d key schedules; %0d results compared",
             key_items, data_items, schedules, checked);
    $display("Failures: %0d", failures);
    if (failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+hdl
hdl/rc4_pkg.sv
hdl/rc4_if.sv
hdl/rc4_ram.sv
hdl/rc4_stream_cipher.sv
test/tb_rc4_stream_cipher.sv
